FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define BBC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants of the LRU block buffer cache.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam int DEVICE_W        = 8;
  localparam int BLOCK_W         = 32;
  localparam int INDEX_W         = 4;
  localparam int TAG_W           = DEVICE_W + BLOCK_W;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_NOFREE  = 3'd3,
    ST_ACCEPT  = 3'd4,
    ST_NOTBUSY = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    XFER_NONE  = 2'd0,
    XFER_READ  = 2'd1,
    XFER_WRITE = 2'd2
  } xfer_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [DEVICE_W-1:0]  device;
    logic [BLOCK_W-1:0]   block_number;
    logic [INDEX_W-1:0]   entry_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   granted_entry;
    xfer_t                start_transfer;
  } rsp_t;

endpackage

FILE: design/bbc_chan_if.sv
// ----------------------------------------------------------------------------
// bbc_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bbc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/block_buffer_cache_lru.sv
// Acquire: the request is registered, the SCAN state reads and compares every
//   entry, then DONE registers the result once rsp is free; the next request is taken back in IDLE.
// Release, write and transfer done: no scan; DONE registers the result once rsp is free.
// Acquire time is set by one tag RAM read and one tag/rank compare per entry.
// rst (synchronous) clears all marks, sets entry i to rank ENTRY_COUNT-1-i;
//   tags are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// LRU buffer cache tag store: acquire by device/block, release, write, done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_buffer_cache_lru #(
  parameter int ENTRY_COUNT = bbc_pkg::ENTRY_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  bbc_chan_if.sink   req,
  bbc_chan_if.source rsp
);
  import bbc_pkg::*;

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRY_COUNT);

  state_t state, state_next;
  req_t   item;

  logic [CNT_W-1:0] cnt;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] free_rank;

  logic [ENTRY_COUNT-1:0] assigned, busy, dirty, valid;
  logic [IDX_W-1:0]       rank [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] head_vec;

  logic             accept, finish;
  logic             tag_re, tag_we;
  logic [IDX_W-1:0] tag_raddr;
  logic [TAG_W-1:0] tag_rdata;
  logic [IDX_W-1:0] cmp_rank;
  logic             tag_match, take_hit, take_free;

  logic [7:0]       idx_wide;
  logic             idx_ok;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] old_rank;
  logic             set_busy, alloc, do_release, do_write, do_done;
  rsp_t             res;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign finish    = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // tag store
  assign tag_re    = (state == S_SCAN) && (cnt < CNT_END);
  assign tag_raddr = cnt[IDX_W-1:0];
  assign tag_we    = finish && alloc;

  bbc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRY_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (free_idx),
    .wdata ({item.device, item.block_number}),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // shared compare unit
  assign cmp_rank  = rank[cmp_idx];
  assign tag_match = assigned[cmp_idx] && (tag_rdata == {item.device, item.block_number});
  assign take_hit  = cmp_valid && tag_match && (!hit_found || (cmp_rank < hit_rank));
  assign take_free = cmp_valid && !busy[cmp_idx] && !dirty[cmp_idx] &&
                     (!free_found || (cmp_rank > free_rank));

  assign idx_wide = 8'(item.entry_index);
  assign idx_ok   = idx_wide < 8'(ENTRY_COUNT);
  assign idx      = IDX_W'(item.entry_index);
  assign old_rank = rank[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.data.mode == MODE_ACQUIRE) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (cnt == CNT_END) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.data;
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      cmp_valid  <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      cnt        <= '0;
      cmp_valid  <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_valid <= tag_re;
      if (tag_re) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (take_hit) begin
        hit_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_re) begin
      cmp_idx <= tag_raddr;
    end
    if (take_hit) begin
      hit_idx  <= cmp_idx;
      hit_rank <= cmp_rank;
    end
    if (take_free) begin
      free_idx  <= cmp_idx;
      free_rank <= cmp_rank;
    end
  end

  // decision
  always_comb begin
    res        = '{status: ST_NOTBUSY, granted_entry: '0, start_transfer: XFER_NONE};
    set_busy   = 1'b0;
    alloc      = 1'b0;
    do_release = 1'b0;
    do_write   = 1'b0;
    do_done    = 1'b0;
    case (item.mode)
      MODE_ACQUIRE: begin
        if (hit_found) begin
          if (busy[hit_idx]) begin
            res.status = ST_BUSY;
          end else begin
            set_busy           = 1'b1;
            res.status         = ST_HIT;
            res.granted_entry  = INDEX_W'(hit_idx);
            res.start_transfer = valid[hit_idx] ? XFER_NONE : XFER_READ;
          end
        end else if (free_found) begin
          alloc              = 1'b1;
          res.status         = ST_MISS;
          res.granted_entry  = INDEX_W'(free_idx);
          res.start_transfer = XFER_READ;
        end else begin
          res.status = ST_NOFREE;
        end
      end
      MODE_RELEASE: begin
        if (idx_ok && busy[idx]) begin
          do_release = 1'b1;
          res.status = ST_ACCEPT;
        end
      end
      MODE_WRITE: begin
        if (idx_ok && busy[idx]) begin
          do_write           = 1'b1;
          res.status         = ST_ACCEPT;
          res.start_transfer = XFER_WRITE;
        end
      end
      MODE_DONE: begin
        if (idx_ok) begin
          do_done    = 1'b1;
          res.status = ST_ACCEPT;
        end
      end
      default: res.status = ST_NOTBUSY;
    endcase
  end

  // entry marks and recency order
  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= '0;
      busy     <= '0;
      dirty    <= '0;
      valid    <= '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        rank[i] <= IDX_W'(ENTRY_COUNT - 1 - i);
      end
    end else if (finish) begin
      if (set_busy) begin
        busy[hit_idx] <= 1'b1;
      end
      if (alloc) begin
        assigned[free_idx] <= 1'b1;
        busy[free_idx]     <= 1'b1;
        dirty[free_idx]    <= 1'b0;
        valid[free_idx]    <= 1'b0;
      end
      if (do_release) begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          if (rank[i] < old_rank) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
        rank[idx] <= '0;
        busy[idx] <= 1'b0;
      end
      if (do_write) begin
        dirty[idx] <= 1'b1;
      end
      if (do_done) begin
        valid[idx] <= 1'b1;
        dirty[idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.data <= res;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      head_vec[i] = (rank[i] == '0);
    end
  end

  `BBC_ASSERT_ALWAYS(a_one_head, $onehot(head_vec), "recency order lost its head")
  `BBC_ASSERT_IMP(a_victim_free, finish && alloc, !busy[free_idx] && !dirty[free_idx], "bad victim")
  `BBC_ASSERT_IMP(a_last_compare, state == S_SCAN && cnt == CNT_END, cmp_valid, "scan ended early")

endmodule

FILE: design/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = bbc_pkg::TAG_W,
  parameter int DEPTH = bbc_pkg::ENTRY_COUNT_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
